@@ design/detrial_pkg.sv @@
// shared types and constants for the differential evolution trial engine
// no dependencies; imported by the engine, the result queue and the top level
`default_nettype none

package detrial_pkg;

  // command codes carried in the input tuser
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TRIAL = 2'd1;
  localparam logic [1:0] CMD_BEST  = 2'd2;

  // status codes carried in the output tuser
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DUP   = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MUT_FACTOR = 2'd0;
  localparam logic [1:0] CFG_CROSS_RATE = 2'd1;
  localparam logic [1:0] CFG_POP_IN_USE = 2'd2;
  localparam logic [1:0] CFG_DIMS_IN_USE = 2'd3;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 64;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         member;
    logic [2:0]         dim_index;
    logic signed [15:0] load_value;
    logic [5:0]         donor_base;
    logic [5:0]         donor_plus;
    logic [5:0]         donor_minus;
    logic [63:0]        cross_draws;
  } trial_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               accepted;
    logic [5:0]         member_index;
    logic [33:0]        fitness;
    logic [2:0]         component_index;
    logic signed [15:0] component_value;
    logic               last;
  } result_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TRIAL,
    S_DECIDE,
    S_WRITE,
    S_SCAN,
    S_BEST_RD,
    S_BEST_OUT,
    S_EMIT
  } eng_state_t;

endpackage

`default_nettype wire

@@ design/detrial_pop_ram.sv @@
// population memory: one write port and two registered read ports
// standalone, contents undefined until written
`default_nettype none

module detrial_pop_ram #(
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re_a,
  input  wire logic [AW-1:0] addr_a,
  output logic      [15:0]   rd_a,
  input  wire logic          re_b,
  input  wire logic [AW-1:0] addr_b,
  output logic      [15:0]   rd_b
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while the port is idle
  always_ff @(posedge clk) begin
    if (re_a) begin
      rd_a <= mem[addr_a];
    end
    if (re_b) begin
      rd_b <= mem[addr_b];
    end
  end

endmodule

`default_nettype wire

@@ design/detrial_out_fifo.sv @@
// two-entry result queue between the engine and the output stream
// depends on detrial_pkg for the result beat type
`default_nettype none

module detrial_out_fifo
  import detrial_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  result_beat_t      push_beat,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output result_beat_t      pop_beat
);

  result_beat_t slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_beat   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/detrial_engine.sv @@
// command sequencer and datapath: loads, trial read-modify-write, best-member scan
// depends on detrial_pkg; drives detrial_pop_ram ports and feeds the result queue
`default_nettype none

module detrial_engine
  import detrial_pkg::*;
#(
  parameter int MAX_MEMBERS = 64,
  parameter int MAX_DIMS = 8,
  localparam int AW = $clog2(MAX_MEMBERS * MAX_DIMS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  trial_item_t        in_item,
  input  wire logic [9:0]    mut_factor,
  input  wire logic [8:0]    cross_rate,
  input  wire logic [6:0]    p_eff,
  input  wire logic [3:0]    d_eff,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output logic [15:0]        wdata,
  output logic               re_a,
  output logic [AW-1:0]      addr_a,
  input  wire logic [15:0]   rd_a,
  output logic               re_b,
  output logic [AW-1:0]      addr_b,
  input  wire logic [15:0]   rd_b,
  output logic               res_valid,
  input  wire logic          res_ready,
  output result_beat_t       res_beat
);

  localparam int MW = $clog2(MAX_MEMBERS);

  function automatic logic [AW-1:0] row_addr(input logic [MW-1:0] m, input logic [2:0] j);
    row_addr = AW'(m) * AW'(MAX_DIMS) + AW'(j);
  endfunction

  eng_state_t state_r, state_nxt;
  trial_item_t item_r;
  result_beat_t res_r;

  logic signed [15:0] rda_s, rdb_s;
  logic [6:0] p_last;
  logic [2:0] d_last;
  logic load_ok, rng_ok, distinct;

  // trial pipeline
  logic [2:0] iss_j_r;
  logic iss_ph_r, iss_done_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [2:0] j1_r, j2_r, j3_r, j4_r, j5_r;
  logic signed [16:0] diff_r;
  logic signed [27:0] prod_r;
  logic signed [15:0] base_r, tgt_r, tri_r, tgt3_r;
  logic [31:0] sq_tri_r, sq_tgt_r;
  logic [33:0] acc_tri_r, acc_tgt_r;
  logic signed [15:0] tri_vec_r [8];
  logic [2:0] wr_j_r;
  logic signed [27:0] rnd_c;
  logic signed [19:0] q_c;
  logic signed [20:0] v_c;
  logic signed [15:0] sat_c, tri_c;
  logic [7:0] draw_c;
  logic signed [31:0] sq_tri_c, sq_tgt_c;
  logic trial_win;

  // best scan
  logic [6:0] sc_i_r;
  logic [1:0] sc_k_r;
  logic sc_done_r;
  logic bv1_r, blast1_r, bodd1_r, bv2_r, blast2_r;
  logic [6:0] bi1_r, bi2_r;
  logic [31:0] sqa_r, sqb_r;
  logic [33:0] msum_r, best_fit_r, scan_sum;
  logic [6:0] best_idx_r;
  logic [2:0] out_j_r;
  logic [3:0] odd_j;
  logic scan_odd_ok, scan_last_pair, scan_fin;
  logic signed [31:0] sqa_c, sqb_c;

  assign rda_s  = rd_a;
  assign rdb_s  = rd_b;
  assign p_last = p_eff - 7'd1;
  assign d_last = 3'(d_eff - 4'd1);

  assign load_ok = ({1'b0, item_r.member} < p_eff) && ({1'b0, item_r.dim_index} < d_eff);
  assign rng_ok  = ({1'b0, item_r.member} < p_eff) && ({1'b0, item_r.donor_base} < p_eff)
                && ({1'b0, item_r.donor_plus} < p_eff) && ({1'b0, item_r.donor_minus} < p_eff);
  assign distinct = (item_r.donor_base != item_r.member) && (item_r.donor_plus != item_r.member)
                 && (item_r.donor_minus != item_r.member)
                 && (item_r.donor_base != item_r.donor_plus)
                 && (item_r.donor_base != item_r.donor_minus)
                 && (item_r.donor_plus != item_r.donor_minus);

  // mutation rounding is round half up on 1/256, then saturate to 16 bits
  assign rnd_c  = prod_r + 28'sd128;
  assign q_c    = rnd_c[27:8];
  assign v_c    = 21'(base_r) + 21'(q_c);
  assign sat_c  = (v_c > 21'sd32767) ? 16'sh7fff :
                  (v_c < -21'sd32768) ? 16'sh8000 : v_c[15:0];
  assign draw_c = item_r.cross_draws[{j3_r, 3'b000} +: 8];
  assign tri_c  = ({1'b0, draw_c} > cross_rate) ? tgt_r : sat_c;
  assign sq_tri_c = tri_r * tri_r;
  assign sq_tgt_c = tgt3_r * tgt3_r;
  assign trial_win = acc_tri_r < acc_tgt_r;

  assign odd_j          = {1'b0, sc_k_r, 1'b1};
  assign scan_odd_ok    = odd_j < d_eff;
  assign scan_last_pair = (odd_j + 4'd1) >= d_eff;
  assign sqa_c    = rda_s * rda_s;
  assign sqb_c    = rdb_s * rdb_s;
  assign scan_sum = msum_r + 34'(sqa_r) + 34'(sqb_r);
  assign scan_fin = bv2_r && blast2_r && (bi2_r == p_last);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (item_r.cmd)
          CMD_LOAD:  state_nxt = S_EMIT;
          CMD_TRIAL: state_nxt = (rng_ok && distinct) ? S_TRIAL : S_EMIT;
          CMD_BEST:  state_nxt = S_SCAN;
          default:   state_nxt = S_EMIT;
        endcase
      end
      S_TRIAL: begin
        if (v5_r && (j5_r == d_last)) state_nxt = S_DECIDE;
      end
      S_DECIDE: state_nxt = trial_win ? S_WRITE : S_EMIT;
      S_WRITE: begin
        if (wr_j_r == d_last) state_nxt = S_EMIT;
      end
      S_SCAN: begin
        if (scan_fin) state_nxt = S_BEST_RD;
      end
      S_BEST_RD: state_nxt = S_BEST_OUT;
      S_BEST_OUT: begin
        if (res_ready) state_nxt = (out_j_r == d_last) ? S_IDLE : S_BEST_RD;
      end
      S_EMIT: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory ports and result handshake
  always_comb begin
    in_ready  = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re_a      = 1'b0;
    addr_a    = '0;
    re_b      = 1'b0;
    addr_b    = '0;
    res_valid = 1'b0;
    res_beat  = '0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_DISPATCH: begin
        if ((item_r.cmd == CMD_LOAD) && load_ok) begin
          we    = 1'b1;
          waddr = row_addr(MW'(item_r.member), item_r.dim_index);
          wdata = item_r.load_value;
        end
      end
      S_TRIAL: begin
        if (!iss_done_r) begin
          re_a = 1'b1;
          re_b = 1'b1;
          if (!iss_ph_r) begin
            addr_a = row_addr(MW'(item_r.donor_plus), iss_j_r);
            addr_b = row_addr(MW'(item_r.donor_minus), iss_j_r);
          end else begin
            addr_a = row_addr(MW'(item_r.donor_base), iss_j_r);
            addr_b = row_addr(MW'(item_r.member), iss_j_r);
          end
        end
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = row_addr(MW'(item_r.member), wr_j_r);
        wdata = tri_vec_r[wr_j_r];
      end
      S_SCAN: begin
        if (!sc_done_r) begin
          re_a   = 1'b1;
          re_b   = 1'b1;
          addr_a = row_addr(MW'(sc_i_r), {sc_k_r, 1'b0});
          addr_b = scan_odd_ok ? row_addr(MW'(sc_i_r), {sc_k_r, 1'b1})
                               : row_addr(MW'(sc_i_r), {sc_k_r, 1'b0});
        end
      end
      S_BEST_RD: begin
        re_a   = 1'b1;
        addr_a = row_addr(MW'(best_idx_r), out_j_r);
      end
      S_BEST_OUT: begin
        res_valid                = 1'b1;
        res_beat.status          = STAT_OK;
        res_beat.member_index    = best_idx_r[5:0];
        res_beat.fitness         = best_fit_r;
        res_beat.component_index = out_j_r;
        res_beat.component_value = rda_s;
        res_beat.last            = (out_j_r == d_last);
      end
      S_EMIT: begin
        res_valid = 1'b1;
        res_beat  = res_r;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      bv1_r   <= 1'b0;
      bv2_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == S_TRIAL) && !iss_done_r && !iss_ph_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      bv1_r   <= (state_r == S_SCAN) && !sc_done_r;
      bv2_r   <= bv1_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      item_r <= in_item;
    end

    if (state_r == S_DISPATCH) begin
      res_r              <= '0;
      res_r.member_index <= item_r.member;
      res_r.last         <= 1'b1;
      iss_j_r    <= 3'd0;
      iss_ph_r   <= 1'b0;
      iss_done_r <= 1'b0;
      acc_tri_r  <= '0;
      acc_tgt_r  <= '0;
      sc_i_r     <= 7'd0;
      sc_k_r     <= 2'd0;
      sc_done_r  <= 1'b0;
      msum_r     <= '0;
      out_j_r    <= 3'd0;
      case (item_r.cmd)
        CMD_LOAD: begin
          res_r.status          <= load_ok ? STAT_OK : STAT_RANGE;
          res_r.component_index <= item_r.dim_index;
          res_r.component_value <= item_r.load_value;
        end
        CMD_TRIAL: res_r.status <= rng_ok ? STAT_DUP : STAT_RANGE;
        CMD_BEST:  res_r.status <= STAT_OK;
        default: begin
          res_r.status       <= STAT_RANGE;
          res_r.member_index <= 6'd0;
        end
      endcase
    end

    // two reads per issue cycle: donors plus/minus, then base/target
    if ((state_r == S_TRIAL) && !iss_done_r) begin
      iss_ph_r <= ~iss_ph_r;
      if (iss_ph_r) begin
        if (iss_j_r == d_last) iss_done_r <= 1'b1;
        else iss_j_r <= iss_j_r + 3'd1;
      end
    end
    j1_r <= iss_j_r;
    j2_r <= j1_r;
    j3_r <= j2_r;
    j4_r <= j3_r;
    j5_r <= j4_r;
    if (v1_r) begin
      diff_r <= 17'(rda_s) - 17'(rdb_s);
    end
    if (v2_r) begin
      prod_r <= $signed({1'b0, mut_factor}) * diff_r;
      base_r <= rda_s;
      tgt_r  <= rdb_s;
    end
    if (v3_r) begin
      tri_r            <= tri_c;
      tgt3_r           <= tgt_r;
      tri_vec_r[j3_r]  <= tri_c;
    end
    if (v4_r) begin
      sq_tri_r <= sq_tri_c;
      sq_tgt_r <= sq_tgt_c;
    end
    if (v5_r) begin
      acc_tri_r <= acc_tri_r + 34'(sq_tri_r);
      acc_tgt_r <= acc_tgt_r + 34'(sq_tgt_r);
    end

    if (state_r == S_DECIDE) begin
      res_r.status   <= STAT_OK;
      res_r.accepted <= trial_win;
      res_r.fitness  <= trial_win ? acc_tri_r : acc_tgt_r;
      wr_j_r         <= 3'd0;
    end
    if (state_r == S_WRITE) begin
      wr_j_r <= wr_j_r + 3'd1;
    end

    // scan: one member row at a time, two components per read
    if ((state_r == S_SCAN) && !sc_done_r) begin
      if (scan_last_pair) begin
        sc_k_r <= 2'd0;
        if (sc_i_r == p_last) sc_done_r <= 1'b1;
        else sc_i_r <= sc_i_r + 7'd1;
      end else begin
        sc_k_r <= sc_k_r + 2'd1;
      end
    end
    bi1_r    <= sc_i_r;
    blast1_r <= scan_last_pair;
    bodd1_r  <= scan_odd_ok;
    bi2_r    <= bi1_r;
    blast2_r <= blast1_r;
    if (bv1_r) begin
      sqa_r <= sqa_c;
      sqb_r <= bodd1_r ? sqb_c : 32'd0;
    end
    if (bv2_r) begin
      if (blast2_r) begin
        msum_r <= '0;
        // strict compare keeps the first minimum
        if ((bi2_r == 7'd0) || (scan_sum < best_fit_r)) begin
          best_fit_r <= scan_sum;
          best_idx_r <= bi2_r;
        end
      end else begin
        msum_r <= scan_sum;
      end
    end

    if ((state_r == S_BEST_OUT) && res_ready) begin
      out_j_r <= out_j_r + 3'd1;
    end
  end

  // the target row is rewritten only for a strictly better trial
  a_write_only_on_win: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> trial_win)
    else $error("population row written without a winning trial");

  // decision waits until every component has left the pipeline
  a_decide_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> (!v1_r && !v2_r && !v3_r && !v4_r && !v5_r))
    else $error("trial decision taken with components in flight");

  // a stalled best-member beat keeps its component value
  a_best_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_BEST_OUT) && !res_ready) |=> (rd_a == $past(rd_a)))
    else $error("best-member component changed while stalled");

endmodule

`default_nettype wire

@@ design/differential_evolution_trial_engine.sv @@
// Differential evolution trial engine (DE/rand/1/bin on Q4.12 vectors). The host loads
// every population component first; a component that was never loaded reads back as
// garbage. A trial reads target and donors through the two read ports of the population
// RAM, two words a cycle, and writes the trial vector back over the target row when the
// trial replaces the target. A best query scans every member in use, two components per
// read, then returns one beat per component. One item is in the block at a time; a
// two-entry result queue lets the next item enter while results wait.
// depends on detrial_pkg, detrial_pop_ram, detrial_engine, detrial_out_fifo
`default_nettype none

module differential_evolution_trial_engine
  import detrial_pkg::*;
#(
  parameter int MAX_MEMBERS = 64,
  parameter int MAX_DIMS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // member, dim_index, load_value, donor_base, donor_plus, donor_minus, cross_draws, pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // accepted, member_index, fitness, component_index, component_value, pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // status
  output logic [1:0]                  out_tuser,
  output logic                        out_tlast,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [9:0]             cfg_wdata
);

  localparam int DEPTH = MAX_MEMBERS * MAX_DIMS;
  localparam int AW = $clog2(DEPTH);

  logic [9:0] mut_factor_r;
  logic [8:0] cross_rate_r;
  logic [6:0] pop_in_use_r;
  logic [3:0] dims_in_use_r;
  logic [6:0] p_eff;
  logic [3:0] d_eff;

  trial_item_t  item;
  result_beat_t eng_beat, q_beat;
  logic eng_valid, eng_ready;

  logic          we, re_a, re_b;
  logic [AW-1:0] waddr, addr_a, addr_b;
  logic [15:0]   wdata, rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mut_factor_r  <= 10'd128;
      cross_rate_r  <= 9'd205;
      pop_in_use_r  <= 7'd50;
      dims_in_use_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MUT_FACTOR:  mut_factor_r  <= cfg_wdata;
        CFG_CROSS_RATE:  cross_rate_r  <= cfg_wdata[8:0];
        CFG_POP_IN_USE:  pop_in_use_r  <= cfg_wdata[6:0];
        CFG_DIMS_IN_USE: dims_in_use_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // counts in use, clamped to at least one and at most the built size
  assign p_eff = (pop_in_use_r == 7'd0) ? 7'd1 :
                 (32'(pop_in_use_r) > MAX_MEMBERS) ? 7'(MAX_MEMBERS) : pop_in_use_r;
  assign d_eff = (dims_in_use_r == 4'd0) ? 4'd1 :
                 (32'(dims_in_use_r) > MAX_DIMS) ? 4'(MAX_DIMS) : dims_in_use_r;

  assign item.cmd         = in_tuser;
  assign item.member      = in_tdata[5:0];
  assign item.dim_index   = in_tdata[8:6];
  assign item.load_value  = in_tdata[24:9];
  assign item.donor_base  = in_tdata[30:25];
  assign item.donor_plus  = in_tdata[36:31];
  assign item.donor_minus = in_tdata[42:37];
  assign item.cross_draws = in_tdata[106:43];

  detrial_pop_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re_a   (re_a),
    .addr_a (addr_a),
    .rd_a   (rd_a),
    .re_b   (re_b),
    .addr_b (addr_b),
    .rd_b   (rd_b)
  );

  detrial_engine #(
    .MAX_MEMBERS(MAX_MEMBERS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (item),
    .mut_factor (mut_factor_r),
    .cross_rate (cross_rate_r),
    .p_eff      (p_eff),
    .d_eff      (d_eff),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re_a       (re_a),
    .addr_a     (addr_a),
    .rd_a       (rd_a),
    .re_b       (re_b),
    .addr_b     (addr_b),
    .rd_b       (rd_b),
    .res_valid  (eng_valid),
    .res_ready  (eng_ready),
    .res_beat   (eng_beat)
  );

  detrial_out_fifo u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (eng_valid),
    .push_ready (eng_ready),
    .push_beat  (eng_beat),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_beat   (q_beat)
  );

  assign out_tdata = {4'b0000, q_beat.component_value, q_beat.component_index,
                      q_beat.fitness, q_beat.member_index, q_beat.accepted};
  assign out_tuser = q_beat.status;
  assign out_tlast = q_beat.last;

endmodule

`default_nettype wire
